FILE: rtl/rrpu_pkg.sv
// Shared types and codes for the raster row pixel unpacker.
// Used by the front end, the back end and the top level.
package rrpu_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DEPTH_MODE   = 2'd2;
  localparam logic [1:0] CFG_RGB_ORDER    = 2'd3;

  // Depth mode codes.
  localparam logic [1:0] DEPTH_1BIT  = 2'd0;
  localparam logic [1:0] DEPTH_8BIT  = 2'd1;
  localparam logic [1:0] DEPTH_24BIT = 2'd2;
  localparam logic [1:0] DEPTH_32BIT = 2'd3;

  // Width of the size registers and of the configuration data.
  localparam int unsigned SizeW = 13;

  // Reset values of the configuration registers.
  localparam logic [SizeW-1:0] WIDTH_RESET  = 13'd1;
  localparam logic [SizeW-1:0] HEIGHT_RESET = 13'd1;
  localparam logic [1:0]       DEPTH_RESET  = DEPTH_8BIT;

  // Default limits on the image size.
  localparam int unsigned MaxWidthDefault  = 4096;
  localparam int unsigned MaxHeightDefault = 4096;

  // One queued pixel group: a byte of one-bit pixels or a single pixel.
  // Position travels beside it, since its width follows the size limits.
  typedef struct packed {
    logic [7:0] red;        // holds the raw byte for one-bit groups
    logic [7:0] green;
    logic [7:0] blue;
    logic       mono;       // one-bit group: expand bits MSB first
    logic [2:0] cnt_m1;     // pixel count minus one
    logic       row_end;    // last pixel of the group ends its row
    logic       frame_end;  // last pixel of the group ends the frame
  } pix_cmd_t;

endpackage

FILE: rtl/raster_row_pixel_unpacker.sv
// Top level of the raster row pixel unpacker.
// Instantiates rrpu_front, rrpu_fifo and rrpu_back; depends on rrpu_pkg.
//
// Raster bytes come in one per transfer and pixels go out one per transfer
// with their column, row and end-of-row/frame/group flags. The front end takes
// a byte every cycle while the two-entry pixel queue has room; the back end
// emits one pixel per cycle from its output register while pixel_ready_i is
// high. In eight-bit mode the sustained rate is one byte per cycle; in 24- and
// 32-bit modes one pixel per three or four bytes, also one byte per cycle; in
// one-bit mode the back end's one-pixel-per-cycle expansion sets the rate for
// the up to 8 pixels of each byte. Row pad bytes give no pixel. A write to
// any configuration register restarts the frame.
module raster_row_pixel_unpacker #(
  parameter int unsigned MAX_WIDTH  = rrpu_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = rrpu_pkg::MaxHeightDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [rrpu_pkg::SizeW-1:0] cfg_wdata_i,
  input  logic                       raster_valid_i,
  output logic                       raster_ready_o,
  input  logic [7:0]                 raster_byte_i,
  output logic                       pixel_valid_o,
  input  logic                       pixel_ready_i,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic [11:0]                column_o,
  output logic [11:0]                row_o,
  output logic                       row_end_o,
  output logic                       frame_end_o,
  output logic                       last_of_item_o
);
  import rrpu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned DW = $bits(pix_cmd_t) + CW + RW;

  logic          push, full, pop, head_valid;
  pix_cmd_t      cmd, head;
  logic [CW-1:0] cmd_col, head_col;
  logic [RW-1:0] cmd_row, head_row;
  logic [DW-1:0] q_wdata, q_rdata;

  // Front end: configuration and byte classification.
  rrpu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .raster_valid_i (raster_valid_i),
    .raster_ready_o (raster_ready_o),
    .raster_byte_i  (raster_byte_i),
    .queue_full_i   (full),
    .push_o         (push),
    .cmd_o          (cmd),
    .cmd_col_o      (cmd_col),
    .cmd_row_o      (cmd_row)
  );

  // Queue of pixel groups with their position.
  assign q_wdata = {cmd, cmd_col, cmd_row};
  assign {head, head_col, head_row} = q_rdata;

  rrpu_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (q_rdata)
  );

  // Back end: pixel expansion and output register.
  rrpu_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .head_col_i     (head_col),
    .head_row_i     (head_row),
    .pop_o          (pop),
    .pixel_valid_o  (pixel_valid_o),
    .pixel_ready_i  (pixel_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .column_o       (column_o),
    .row_o          (row_o),
    .row_end_o      (row_end_o),
    .frame_end_o    (frame_end_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule

FILE: rtl/rrpu_front.sv
// Front end: configuration registers, input byte transfer, pad skipping,
// channel gathering and row/column tracking per byte. Depends on rrpu_pkg.
module rrpu_front #(
  parameter int unsigned MAX_WIDTH  = rrpu_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = rrpu_pkg::MaxHeightDefault,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [rrpu_pkg::SizeW-1:0]  cfg_wdata_i,
  input  logic                        raster_valid_i,
  output logic                        raster_ready_o,
  input  logic [7:0]                  raster_byte_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output rrpu_pkg::pix_cmd_t          cmd_o,
  output logic [CW-1:0]               cmd_col_o,
  output logic [RW-1:0]               cmd_row_o
);
  import rrpu_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MW   = (WW > HW) ? WW : HW;
  localparam int unsigned CMPW = (MW > SizeW) ? MW : SizeW;

  logic [SizeW-1:0] width_q, width_d, height_q, height_d;
  logic [1:0]       depth_q, depth_d;
  logic             order_q, order_d;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       first_q, first_d, second_q, second_d;
  logic             parity_q, parity_d;
  logic             pad_q, pad_d;

  logic [CMPW-1:0] wid_ext, hgt_ext, eff_w, eff_h, col_ext, row_ext, left;
  logic [CMPW:0]   col_sum, row_sum;
  logic [3:0]      cnt;
  logic            accept, emit, rend, fend, base;

  // Effective size: zero counts as one, large values saturate.
  assign wid_ext = CMPW'(width_q);
  assign hgt_ext = CMPW'(height_q);
  assign eff_w = (width_q == '0) ? CMPW'(1) :
                 (wid_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : wid_ext;
  assign eff_h = (height_q == '0) ? CMPW'(1) :
                 (hgt_ext > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : hgt_ext;

  // Pixels this byte covers and whether the row and frame end with it.
  assign col_ext = CMPW'(col_q);
  assign row_ext = CMPW'(row_q);
  assign left    = eff_w - col_ext;
  always_comb begin
    if (depth_q == DEPTH_1BIT) begin
      cnt = (left > CMPW'(8)) ? 4'd8 : left[3:0];
    end else begin
      cnt = 4'd1;
    end
  end
  assign col_sum = {1'b0, col_ext} + (CMPW + 1)'(cnt);
  assign row_sum = {1'b0, row_ext} + (CMPW + 1)'(1);
  assign rend    = col_sum >= {1'b0, eff_w};
  assign fend    = rend && (row_sum >= {1'b0, eff_h});
  assign base    = (depth_q == DEPTH_32BIT);

  assign raster_ready_o = !queue_full_i;
  assign accept         = raster_valid_i && raster_ready_o;

  // Next state for configuration, pad skipping, channel gathering and position.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    order_d  = order_q;
    col_d    = col_q;
    row_d    = row_q;
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    parity_d = parity_q;
    pad_d    = pad_q;
    emit     = 1'b0;
    cmd_o    = '0;
    cmd_o.cnt_m1    = 3'(cnt - 4'd1);
    cmd_o.row_end   = rend;
    cmd_o.frame_end = fend;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_d  = cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_d = cfg_wdata_i;
        CFG_DEPTH_MODE:   depth_d  = cfg_wdata_i[1:0];
        CFG_RGB_ORDER:    order_d  = cfg_wdata_i[0];
        default: ;
      endcase
      // Any write starts a fresh frame.
      col_d    = '0;
      row_d    = '0;
      phase_d  = '0;
      first_d  = '0;
      second_d = '0;
      parity_d = 1'b0;
      pad_d    = 1'b0;
    end else if (accept) begin
      if (pad_q) begin
        pad_d = 1'b0;
      end else begin
        parity_d = ~parity_q;
        case (depth_q)
          DEPTH_1BIT: begin
            emit       = 1'b1;
            cmd_o.mono = 1'b1;
            cmd_o.red  = raster_byte_i;
          end
          DEPTH_8BIT: begin
            emit        = 1'b1;
            cmd_o.red   = raster_byte_i;
            cmd_o.green = raster_byte_i;
            cmd_o.blue  = raster_byte_i;
          end
          default: begin
            if (phase_q < {1'b0, base}) begin
              phase_d = phase_q + 2'd1;
            end else if (phase_q == {1'b0, base}) begin
              first_d = raster_byte_i;
              phase_d = phase_q + 2'd1;
            end else if (phase_q == ({1'b0, base} + 2'd1)) begin
              second_d = raster_byte_i;
              phase_d  = phase_q + 2'd1;
            end else begin
              emit        = 1'b1;
              phase_d     = '0;
              cmd_o.green = second_q;
              if (order_q) begin
                cmd_o.red  = first_q;
                cmd_o.blue = raster_byte_i;
              end else begin
                cmd_o.red  = raster_byte_i;
                cmd_o.blue = first_q;
              end
            end
          end
        endcase
        // Advance the position by the pixels this byte produced.
        if (emit) begin
          if (rend) begin
            col_d    = '0;
            phase_d  = '0;
            pad_d    = ~parity_q;
            parity_d = 1'b0;
            row_d    = fend ? '0 : RW'(row_sum);
          end else begin
            col_d = CW'(col_sum);
          end
        end
      end
    end
  end

  assign push_o    = emit;
  assign cmd_col_o = col_q;
  assign cmd_row_o = row_q;

  // Configuration and position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      depth_q  <= DEPTH_RESET;
      order_q  <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      phase_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      parity_q <= 1'b0;
      pad_q    <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      order_q  <= order_d;
      col_q    <= col_d;
      row_q    <= row_d;
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      parity_q <= parity_d;
      pad_q    <= pad_d;
    end
  end

endmodule

FILE: rtl/rrpu_fifo.sv
// Two-entry queue of pixel groups between the front end and the back end.
// Generic in data width; depends on nothing else.
module rrpu_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage: written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/rrpu_back.sv
// Back end: expands queued pixel groups into single pixels, one per cycle
// while pixel_ready_i allows, into an output register. Depends on rrpu_pkg.
module rrpu_back #(
  parameter int unsigned MAX_WIDTH  = rrpu_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = rrpu_pkg::MaxHeightDefault,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  rrpu_pkg::pix_cmd_t head_i,
  input  logic [CW-1:0]      head_col_i,
  input  logic [RW-1:0]      head_row_i,
  output logic               pop_o,
  output logic               pixel_valid_o,
  input  logic               pixel_ready_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [11:0]        column_o,
  output logic [11:0]        row_o,
  output logic               row_end_o,
  output logic               frame_end_o,
  output logic               last_of_item_o
);
  import rrpu_pkg::*;

  localparam int unsigned PW  = (CW > RW) ? CW : RW;
  localparam int unsigned XW  = (PW > 12) ? PW : 12;

  logic [2:0]    idx_q, idx_d;
  logic          valid_q, valid_d;
  logic [7:0]    red_q, green_q, blue_q;
  logic [XW-1:0] col_q, row_q;
  logic          rend_q, fend_q, last_q;

  logic          load, last;
  logic [7:0]    shifted, mono_val;
  logic [CW-1:0] pix_col;

  // Load a new pixel whenever the output register is free or drains.
  assign load     = head_valid_i && (!valid_q || pixel_ready_i);
  assign last     = (idx_q == head_i.cnt_m1);
  assign pop_o    = load && last;
  assign shifted  = head_i.red << idx_q;
  assign mono_val = shifted[7] ? 8'h00 : 8'hFF;
  assign pix_col  = head_col_i + CW'(idx_q);

  // Pixel index within the current group and output valid.
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last ? 3'd0 : idx_q + 3'd1;
    end else if (pixel_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= head_i.mono ? mono_val : head_i.red;
      green_q <= head_i.mono ? mono_val : head_i.green;
      blue_q  <= head_i.mono ? mono_val : head_i.blue;
      col_q   <= XW'(pix_col);
      row_q   <= XW'(head_row_i);
      rend_q  <= last && head_i.row_end;
      fend_q  <= last && head_i.frame_end;
      last_q  <= last;
    end
  end

  assign pixel_valid_o  = valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign column_o       = col_q[11:0];
  assign row_o          = row_q[11:0];
  assign row_end_o      = rend_q;
  assign frame_end_o    = fend_q;
  assign last_of_item_o = last_q;

endmodule
